>>> rtl/rcb_pkg.sv
package rcb_pkg;

	localparam int ENDPOINTS = 16;
	localparam int EP_W = $clog2(ENDPOINTS);

	localparam int SHIFT_LIMIT = 10;
	localparam int DELAY_W = 26;
	localparam int CNT_W = 8;
	localparam int TIME_W = 32;
	localparam int ADDR_W = 5;

	// action codes
	localparam logic [1:0] ACT_REQUEST = 2'd0;
	localparam logic [1:0] ACT_REPORT = 2'd1;
	localparam logic [1:0] ACT_RESET = 2'd2;

	// outcome codes
	localparam logic [1:0] OUT_OK = 2'd0;
	localparam logic [1:0] OUT_RETRYABLE = 2'd1;

	// verdict codes
	localparam logic [2:0] V_SUBMIT = 3'd0;
	localparam logic [2:0] V_RETRY = 3'd1;
	localparam logic [2:0] V_OK = 3'd2;
	localparam logic [2:0] V_FAILED = 3'd3;
	localparam logic [2:0] V_EXHAUSTED = 3'd4;
	localparam logic [2:0] V_OPEN = 3'd5;
	localparam logic [2:0] V_RESET_DONE = 3'd6;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_RETRY_LIMIT = 3'd0;
	localparam logic [2:0] REG_BASE_DELAY = 3'd1;
	localparam logic [2:0] REG_DELAY_CAP = 3'd2;
	localparam logic [2:0] REG_TRIP = 3'd3;
	localparam logic [2:0] REG_COOLDOWN = 3'd4;

	localparam logic [7:0] RST_RETRY_LIMIT = 8'd3;
	localparam logic [15:0] RST_BASE_DELAY = 16'd100;
	localparam logic [DELAY_W-1:0] RST_DELAY_CAP = 26'd10000;
	localparam logic [7:0] RST_TRIP = 8'd5;
	localparam logic [TIME_W-1:0] RST_COOLDOWN = 32'd30000;

	// base shifted by min(attempt, limit), clipped to the cap; 16 + 10 bits never overflow
	function automatic logic [DELAY_W-1:0] backoff(
		input logic [CNT_W-1:0] att,
		input logic [15:0] base,
		input logic [DELAY_W-1:0] cap
	);
		logic [3:0] sh;
		logic [DELAY_W-1:0] d;
		sh = (att < CNT_W'(SHIFT_LIMIT)) ? att[3:0] : 4'(SHIFT_LIMIT);
		d = DELAY_W'(base) << sh;
		return (d > cap) ? cap : d;
	endfunction

endpackage

>>> rtl/retry_circuit_breaker.sv
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// command  | start, busy              | action, endpoint, outcome, now_ms
// result   | done (one-cycle strobe)  | verdict, delay_ms, attempt_number,
//          |                          | breaker_open, failure_count, *_total
// config   | psel, penable, pwrite,   | paddr, pwdata, prdata
//          | pready                   |
//
// one transfer per cycle; busy stays low. the command is registered at the accepting
// edge, the breaker table update and result register follow at the next edge, and done
// is driven from the result register. the table is 16 flop entries read and
// written at one endpoint, so back-to-back commands on one endpoint see fresh state.
// reset closes every breaker, clears all counters and loads the register defaults.
// the receiver cannot stall: done marks each result for one cycle only.
module retry_circuit_breaker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            action,
	input  logic [rcb_pkg::EP_W-1:0]              endpoint,
	input  logic [1:0]                            outcome,
	input  logic [rcb_pkg::TIME_W-1:0]            now_ms,
	output logic                                  done,
	output logic [2:0]                            verdict,
	output logic [rcb_pkg::DELAY_W-1:0]           delay_ms,
	output logic [rcb_pkg::CNT_W-1:0]             attempt_number,
	output logic                                  breaker_open,
	output logic [rcb_pkg::CNT_W-1:0]             failure_count,
	output logic [31:0]                           calls_total,
	output logic [31:0]                           retries_total,
	output logic [31:0]                           rejections_total,
	output logic [31:0]                           successes_total,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [rcb_pkg::ADDR_W-1:0]            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	// configuration
	logic [7:0]                       retry_limit_q;
	logic [15:0]                      base_delay_q;
	logic [rcb_pkg::DELAY_W-1:0]      delay_cap_q;
	logic [7:0]                       trip_q;
	logic [rcb_pkg::TIME_W-1:0]       cooldown_q;
	logic                             cfg_wr;
	logic [2:0]                       reg_idx;

	// command stage
	logic                             valid_s1;
	logic [1:0]                       action_s1;
	logic [rcb_pkg::EP_W-1:0]         ep_s1;
	logic [1:0]                       outcome_s1;
	logic [rcb_pkg::TIME_W-1:0]       now_s1;

	// breaker table
	logic [rcb_pkg::CNT_W-1:0]        fail_cnt_q [rcb_pkg::ENDPOINTS];
	logic                             open_flag_q [rcb_pkg::ENDPOINTS];
	logic [rcb_pkg::TIME_W-1:0]       fail_time_q [rcb_pkg::ENDPOINTS];
	logic [rcb_pkg::CNT_W-1:0]        attempt_q [rcb_pkg::ENDPOINTS];

	logic [31:0]                      call_q;
	logic [31:0]                      retry_q;
	logic [31:0]                      reject_q;
	logic [31:0]                      success_q;

	// result register
	logic                             done_q;
	logic [2:0]                       verdict_q;
	logic [rcb_pkg::DELAY_W-1:0]      delay_q;
	logic [rcb_pkg::CNT_W-1:0]        res_attempt_q;
	logic                             res_open_q;
	logic [rcb_pkg::CNT_W-1:0]        res_fail_q;

	// next-state logic
	logic [rcb_pkg::CNT_W-1:0]        cur_fail;
	logic                             cur_open;
	logic [rcb_pkg::TIME_W-1:0]       cur_time;
	logic [rcb_pkg::CNT_W-1:0]        cur_att;
	logic [rcb_pkg::TIME_W-1:0]       elapsed;
	logic [rcb_pkg::CNT_W-1:0]        nxt_fail;
	logic                             nxt_open;
	logic [rcb_pkg::TIME_W-1:0]       nxt_time;
	logic [rcb_pkg::CNT_W-1:0]        nxt_att;
	logic [2:0]                       nxt_verdict;
	logic [rcb_pkg::DELAY_W-1:0]      nxt_delay;
	logic                             inc_call;
	logic                             inc_retry;
	logic                             inc_reject;
	logic                             inc_success;

	assign busy = 1'b0;
	assign pready = 1'b1;
	assign reg_idx = paddr[rcb_pkg::ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= rcb_pkg::RST_RETRY_LIMIT;
			base_delay_q <= rcb_pkg::RST_BASE_DELAY;
			delay_cap_q <= rcb_pkg::RST_DELAY_CAP;
			trip_q <= rcb_pkg::RST_TRIP;
			cooldown_q <= rcb_pkg::RST_COOLDOWN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				rcb_pkg::REG_RETRY_LIMIT: retry_limit_q <= pwdata[7:0];
				rcb_pkg::REG_BASE_DELAY:  base_delay_q <= pwdata[15:0];
				rcb_pkg::REG_DELAY_CAP:   delay_cap_q <= pwdata[rcb_pkg::DELAY_W-1:0];
				rcb_pkg::REG_TRIP:        trip_q <= pwdata[7:0];
				rcb_pkg::REG_COOLDOWN:    cooldown_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rcb_pkg::REG_RETRY_LIMIT: prdata = 32'(retry_limit_q);
			rcb_pkg::REG_BASE_DELAY:  prdata = 32'(base_delay_q);
			rcb_pkg::REG_DELAY_CAP:   prdata = 32'(delay_cap_q);
			rcb_pkg::REG_TRIP:        prdata = 32'(trip_q);
			rcb_pkg::REG_COOLDOWN:    prdata = cooldown_q;
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1 <= action;
			ep_s1 <= endpoint;
			outcome_s1 <= outcome;
			now_s1 <= now_ms;
		end
	end

	assign cur_fail = fail_cnt_q[ep_s1];
	assign cur_open = open_flag_q[ep_s1];
	assign cur_time = fail_time_q[ep_s1];
	assign cur_att = attempt_q[ep_s1];
	assign elapsed = now_s1 - cur_time;

	always_comb begin
		nxt_fail = cur_fail;
		nxt_open = cur_open;
		nxt_time = cur_time;
		nxt_att = cur_att;
		nxt_verdict = rcb_pkg::V_FAILED;
		nxt_delay = '0;
		inc_call = 1'b0;
		inc_retry = 1'b0;
		inc_reject = 1'b0;
		inc_success = 1'b0;
		case (action_s1)
			rcb_pkg::ACT_REQUEST: begin
				inc_call = 1'b1;
				// cooldown over: close before judging the request
				if (cur_open && (elapsed > cooldown_q)) begin
					nxt_open = 1'b0;
					nxt_fail = '0;
				end
				if (nxt_open) begin
					inc_reject = 1'b1;
					nxt_verdict = rcb_pkg::V_OPEN;
				end else begin
					nxt_att = '0;
					nxt_verdict = rcb_pkg::V_SUBMIT;
				end
			end
			rcb_pkg::ACT_REPORT: begin
				case (outcome_s1)
					rcb_pkg::OUT_OK: begin
						nxt_fail = '0;
						nxt_open = 1'b0;
						inc_success = 1'b1;
						nxt_verdict = rcb_pkg::V_OK;
					end
					rcb_pkg::OUT_RETRYABLE: begin
						if (cur_fail != '1) begin
							nxt_fail = cur_fail + 1'b1;
						end
						nxt_time = now_s1;
						if (nxt_fail >= trip_q) begin
							nxt_open = 1'b1;
						end
						if (cur_att < retry_limit_q) begin
							nxt_att = cur_att + 1'b1;
							inc_retry = 1'b1;
							nxt_delay = rcb_pkg::backoff(nxt_att, base_delay_q, delay_cap_q);
							nxt_verdict = rcb_pkg::V_RETRY;
						end else begin
							nxt_verdict = rcb_pkg::V_EXHAUSTED;
						end
					end
					default: nxt_verdict = rcb_pkg::V_FAILED;
				endcase
			end
			rcb_pkg::ACT_RESET: begin
				nxt_open = 1'b0;
				nxt_fail = '0;
				nxt_verdict = rcb_pkg::V_RESET_DONE;
			end
			default: nxt_verdict = rcb_pkg::V_FAILED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcb_pkg::ENDPOINTS; i++) begin
				fail_cnt_q[i] <= '0;
				open_flag_q[i] <= 1'b0;
				fail_time_q[i] <= '0;
				attempt_q[i] <= '0;
			end
			call_q <= '0;
			retry_q <= '0;
			reject_q <= '0;
			success_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				fail_cnt_q[ep_s1] <= nxt_fail;
				open_flag_q[ep_s1] <= nxt_open;
				fail_time_q[ep_s1] <= nxt_time;
				attempt_q[ep_s1] <= nxt_att;
				call_q <= call_q + 32'(inc_call);
				retry_q <= retry_q + 32'(inc_retry);
				reject_q <= reject_q + 32'(inc_reject);
				success_q <= success_q + 32'(inc_success);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			verdict_q <= nxt_verdict;
			delay_q <= nxt_delay;
			res_attempt_q <= nxt_att;
			res_open_q <= nxt_open;
			res_fail_q <= nxt_fail;
		end
	end

	assign done = done_q;
	assign verdict = verdict_q;
	assign delay_ms = delay_q;
	assign attempt_number = res_attempt_q;
	assign breaker_open = res_open_q;
	assign failure_count = res_fail_q;
	// counters only move at the edge that loads the result register
	assign calls_total = call_q;
	assign retries_total = retry_q;
	assign rejections_total = reject_q;
	assign successes_total = success_q;

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted command gave no result");

	a_delay_only_on_retry: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (verdict != rcb_pkg::V_RETRY)) |-> (delay_ms == '0))
		else $error("delay given without a retry");

	a_reject_means_open: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (verdict == rcb_pkg::V_OPEN)) |-> breaker_open)
		else $error("request refused while breaker closed");

	a_submit_resets_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (verdict == rcb_pkg::V_SUBMIT)) |-> ((attempt_number == '0) && !breaker_open))
		else $error("submitted call with stale attempt or open breaker");

	a_retry_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(retry_q) |-> (done && (verdict == rcb_pkg::V_RETRY)))
		else $error("retry counter moved without a granted retry");
`endif

endmodule
